FILE: rtl/core/gpd_pkg.sv
// gpd_pkg: shared types, constants and the per-channel predictor function
// for the gradient predict pixel decoder; depends on nothing
package gpd_pkg;

	// channel and pixel geometry
	localparam int CH_W   = 8;
	localparam int PIX_W  = 24;
	localparam int CFG_W  = 12;
	localparam int ROW_W  = 11;
	localparam int RED_LSB   = 16;
	localparam int GREEN_LSB = 8;
	localparam int BLUE_LSB  = 0;

	// channel clamp ceiling and height limit
	localparam logic [CH_W-1:0]  CH_MAX       = 8'd255;
	localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 12'd2048;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_RECT_WIDTH  = 1'b0,
		CFG_RECT_HEIGHT = 1'b1
	} cfg_idx_t;

	// input word: one residual pixel
	typedef struct packed {
		logic [CH_W-1:0] res_red;
		logic [CH_W-1:0] res_green;
		logic [CH_W-1:0] res_blue;
	} gpd_in_t;

	// output word: one reconstructed pixel with marks
	typedef struct packed {
		logic [PIX_W-1:0] pixel_rgb;
		logic             row_end;
		logic             rect_end;
	} gpd_out_t;

	// residual + left + above - above_left, clamped to 0..255
	function automatic logic [CH_W-1:0] predict_chan(
		input logic [CH_W-1:0] res,
		input logic [CH_W-1:0] l,
		input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] al
	);
		logic signed [CH_W+2:0] sum;
		logic [CH_W-1:0]        val;
		sum = $signed({3'b000, res}) + $signed({3'b000, l})
			+ $signed({3'b000, a}) - $signed({3'b000, al});
		if (sum[CH_W+2]) begin
			val = '0;
		end else if (sum > $signed({3'b000, CH_MAX})) begin
			val = CH_MAX;
		end else begin
			val = sum[CH_W-1:0];
		end
		return val;
	endfunction

endpackage

FILE: rtl/core/gpd_ram.sv
// gpd_ram: generic single-write, single-read memory with registered read
// no dependencies; contents are undefined until written
module gpd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/gpd_predict.sv
// gpd_predict: gradient prediction and clamp for all three channels
// depends on gpd_pkg for the word types and the channel function
module gpd_predict import gpd_pkg::*; (
	input  gpd_in_t          res,
	input  logic [PIX_W-1:0] left,
	input  logic [PIX_W-1:0] above,
	input  logic [PIX_W-1:0] above_left,
	output logic [PIX_W-1:0] pix
);

	// one predictor per channel
	assign pix[RED_LSB+:CH_W] = predict_chan(res.res_red, left[RED_LSB+:CH_W],
		above[RED_LSB+:CH_W], above_left[RED_LSB+:CH_W]);
	assign pix[GREEN_LSB+:CH_W] = predict_chan(res.res_green, left[GREEN_LSB+:CH_W],
		above[GREEN_LSB+:CH_W], above_left[GREEN_LSB+:CH_W]);
	assign pix[BLUE_LSB+:CH_W] = predict_chan(res.res_blue, left[BLUE_LSB+:CH_W],
		above[BLUE_LSB+:CH_W], above_left[BLUE_LSB+:CH_W]);

endmodule

FILE: rtl/core/gradient_predict_pixel_decoder_unit.sv
// gradient_predict_pixel_decoder_unit: top level of the gradient predict decoder
// depends on gpd_pkg, gpd_ram (line store) and gpd_predict (channel math)
//
// usage:
//   in channel (in_valid/in_stall/in_data) takes one residual pixel word per
//   cycle while in_stall is low, raster order over rect_width x rect_height.
//   out channel (out_valid/out_stall/out_data) returns one 0xRRGGBB pixel per
//   input word, with row_end and rect_end marks; counters restart after
//   rect_end.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes rect_width
//   (index 0) or rect_height (index 1); always ready, write only while idle.
// timing:
//   an accepted word is registered in the compute stage, then in the output
//   register, where the out channel shows it; one word per cycle sustained
//   while out_stall is low. The line store read is issued at the accept edge
//   and the left-neighbor add and clamp closes within the compute stage.
// reset:
//   clears the counters, neighbors and valids; width and height go to 1.
//   The line store is not cleared: the first row never uses its read data.
// stall:
//   a stalled output word holds in the output register; the compute stage
//   still fills, then in_stall rises until the receiver takes the word.
module gradient_predict_pixel_decoder_unit import gpd_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  gpd_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output gpd_out_t         out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = ((CW + 1) > CFG_W) ? (CW + 1) : CFG_W;
	localparam logic [LW-1:0] W_MAX = LW'(MAX_WIDTH);

	// configuration registers
	logic [CFG_W-1:0] rect_width_q;
	logic [CFG_W-1:0] rect_height_q;

	// position counters
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	// compute stage
	logic             s1_valid;
	gpd_in_t          res_s1;
	logic [CW-1:0]    col_s1;
	logic             first_col_s1;
	logic             first_row_s1;
	logic             row_end_s1;
	logic             rect_end_s1;
	logic             byp_s1;

	// neighbors and output register
	logic [PIX_W-1:0] left_q;
	logic [PIX_W-1:0] above_left_q;
	logic             out_valid_q;
	gpd_out_t         out_q;

	logic             s1_adv;
	logic             accept;
	logic             wr_en;
	logic [LW-1:0]    w_eff;
	logic [CFG_W-1:0] h_eff;
	logic [LW-1:0]    col_inc;
	logic [CFG_W-1:0] row_inc;
	logic             row_end_nx;
	logic             rect_end_nx;
	logic [PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] above;
	logic [PIX_W-1:0] left;
	logic [PIX_W-1:0] above_left;
	logic [PIX_W-1:0] pix;

	// handshake
	assign s1_adv    = s1_valid && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid && !s1_adv;
	assign accept    = in_valid && !in_stall;
	assign wr_en     = s1_adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// effective rectangle size
	always_comb begin
		w_eff = LW'(rect_width_q);
		if (rect_width_q == '0) begin
			w_eff = LW'(1);
		end else if (w_eff > W_MAX) begin
			w_eff = W_MAX;
		end
		h_eff = rect_height_q;
		if (rect_height_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (rect_height_q > HEIGHT_LIMIT) begin
			h_eff = HEIGHT_LIMIT;
		end
	end

	// end-of-row and end-of-rectangle for the word being accepted
	assign col_inc     = LW'(col_q) + LW'(1);
	assign row_inc     = CFG_W'(row_q) + CFG_W'(1);
	assign row_end_nx  = col_inc >= w_eff;
	assign rect_end_nx = row_end_nx && (row_inc >= h_eff);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_width_q  <= CFG_W'(1);
			rect_height_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RECT_WIDTH:  rect_width_q  <= cfg_data;
				CFG_RECT_HEIGHT: rect_height_q <= cfg_data;
			endcase
		end
	end

	// counters and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			s1_valid     <= 1'b0;
			out_valid_q  <= 1'b0;
			left_q       <= '0;
			above_left_q <= '0;
		end else begin
			if (accept) begin
				if (row_end_nx) begin
					col_q <= '0;
					row_q <= rect_end_nx ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q  <= 1'b1;
				left_q       <= pix;
				above_left_q <= above;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// compute stage and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1       <= in_data;
			col_s1       <= col_q;
			first_col_s1 <= (col_q == '0);
			first_row_s1 <= (row_q == '0);
			row_end_s1   <= row_end_nx;
			rect_end_s1  <= rect_end_nx;
			byp_s1       <= wr_en && (col_s1 == col_q);
		end
		if (s1_adv) begin
			out_q.pixel_rgb <= pix;
			out_q.row_end   <= row_end_s1;
			out_q.rect_end  <= rect_end_s1;
		end
	end

	// line store of the previous row
	gpd_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (col_s1),
		.wr_data (pix),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data)
	);

	// neighbor selection; bypass covers a same-column write at the read edge
	always_comb begin
		above      = first_row_s1 ? '0 : (byp_s1 ? left_q : rd_data);
		left       = first_col_s1 ? '0 : left_q;
		above_left = first_col_s1 ? '0 : above_left_q;
	end

	gpd_predict u_predict (
		.res        (res_s1),
		.left       (left),
		.above      (above),
		.above_left (above_left),
		.pix        (pix)
	);

`ifndef ASSERT_OFF
	// rectangle end is always also a row end
	a_rect_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.rect_end || out_q.row_end))
		else $error("rect_end without row_end");

	// an accepted word always lands in the compute stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid)
		else $error("accepted word lost before compute stage");

	// a word leaving the compute stage always reaches the output register
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid_q)
		else $error("computed word lost before output");

	// the column counter restarts after a row end
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && row_end_nx) |=> (col_q == '0))
		else $error("column counter did not restart");
`endif

endmodule
